// File: hw/rtl/bba_pkg.sv
// Shared types and constants of the bitmap block allocator.
`default_nettype none
package bba_pkg;

  localparam int unsigned WORD_W    = 32;  // marks per memory word
  localparam int unsigned BIT_W     = 5;   // bit position within a word
  localparam int unsigned BLK_W     = 10;  // block index width
  localparam int unsigned CNT_W     = 11;  // block count width
  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned CFG_W     = 11;

  typedef enum logic [1:0] {
    FUNC_ALLOC = 2'd0,
    FUNC_FREE  = 2'd1,
    FUNC_MARK  = 2'd2,
    FUNC_QUERY = 2'd3
  } func_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BLOCK_COUNT = 1'b0,
    CFG_FIRST_DATA  = 1'b1
  } cfg_idx_e;

  typedef struct packed {
    func_e            func;
    logic [BLK_W-1:0] block;
  } bba_in_t;

  typedef struct packed {
    logic [BLK_W-1:0] granted_block;
    logic             alloc_ok;
    logic             block_used;
    logic             out_of_range;
  } bba_out_t;

  // Limits of the scan window inside the word under test.
  typedef struct packed {
    logic             is_first;
    logic             is_last;
    logic [BIT_W-1:0] lo_bit;
    logic [BIT_W-1:0] hi_bit;
  } scan_ctl_t;

  typedef struct packed {
    logic             found;
    logic [BIT_W-1:0] bit_idx;
  } scan_res_t;

endpackage
`default_nettype wire

// File: hw/rtl/bba_ram.sv
// Generic simple dual-port RAM with registered read.
`default_nettype none
module bba_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 32,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

// File: hw/rtl/bba_word_scan.sv
// Lowest free mark within one bitmap word, limited to the scan window.
`default_nettype none
module bba_word_scan
  import bba_pkg::*;
(
  input  wire logic [WORD_W-1:0] word_i,
  input  wire scan_ctl_t         ctl_i,
  output scan_res_t              res_o
);

  logic [WORD_W-1:0] avail;

  always_comb begin
    for (int j = 0; j < WORD_W; j++) begin
      avail[j] = !word_i[j]
                 && (!ctl_i.is_first || (BIT_W'(j) >= ctl_i.lo_bit))
                 && (!ctl_i.is_last  || (BIT_W'(j) <= ctl_i.hi_bit));
    end
  end

  always_comb begin
    res_o.found   = |avail;
    res_o.bit_idx = '0;
    for (int j = WORD_W - 1; j >= 0; j--) begin
      if (avail[j]) begin
        res_o.bit_idx = BIT_W'(j);
      end
    end
  end

endmodule
`default_nettype wire

// File: hw/rtl/bitmap_block_allocator.sv
// Bitmap first-fit block allocator: control, config and bitmap memory.
// In-range free, mark-used and query pass through S_RD, S_MOD and S_DONE after the input
// transfer; allocate scans bitmap words in S_SCAN (32 marks per word, at most 32 words for
// 1024 blocks); out-of-range requests and allocate with start >= count skip to S_DONE.
// One request in flight: input stalls outside S_IDLE, and S_DONE waits for the output register.
// Reset: a clearing pass writes every bitmap word with input stalled.
`default_nettype none
module bitmap_block_allocator
  import bba_pkg::*;
#(
  parameter int unsigned NUM_BLOCKS = 1024
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_stall_o,
  input  wire bba_in_t              in_data_i,
  output logic                      out_valid_o,
  input  wire logic                 out_stall_i,
  output bba_out_t                  out_data_o,
  input  wire logic                 cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [CFG_W-1:0]     cfg_wdata_i
);

  localparam int unsigned DEPTH  = (NUM_BLOCKS + WORD_W - 1) / WORD_W;
  localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  typedef enum logic [5:0] {
    S_CLEAR = 6'b000001,
    S_IDLE  = 6'b000010,
    S_RD    = 6'b000100,
    S_MOD   = 6'b001000,
    S_SCAN  = 6'b010000,
    S_DONE  = 6'b100000
  } state_e;

  state_e            state_q, state_d;
  logic [CNT_W-1:0]  blk_cnt_q;
  logic [BLK_W-1:0]  first_q;
  logic [ADDR_W-1:0] clr_q, clr_d;
  logic [ADDR_W-1:0] scan_addr_q, scan_addr_d;
  logic [ADDR_W-1:0] chk_addr_q, chk_addr_d;
  logic              chk_vld_q, chk_vld_d;
  logic              iss_done_q, iss_done_d;
  bba_in_t           req_q, req_d;
  bba_out_t          res_q, res_d;
  bba_out_t          out_q, out_d;
  logic              out_vld_q, out_vld_d;

  logic [CNT_W-1:0]  eff;
  logic [CNT_W-1:0]  eff_m1;
  logic [ADDR_W-1:0] first_word;
  logic [ADDR_W-1:0] last_word;
  logic              in_oor;
  logic              alloc_none;
  logic              in_xfer;

  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [WORD_W-1:0] ram_wdata;
  logic              ram_re;
  logic [ADDR_W-1:0] ram_raddr;
  logic [WORD_W-1:0] ram_rdata;
  logic [WORD_W-1:0] req_onehot;

  scan_ctl_t         scan_ctl;
  scan_res_t         scan_res;

  // Config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      blk_cnt_q <= '0;
      first_q   <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_BLOCK_COUNT: blk_cnt_q <= cfg_wdata_i;
        CFG_FIRST_DATA:  first_q   <= cfg_wdata_i[BLK_W-1:0];
        default: ;
      endcase
    end
  end

  // Count saturates at the capacity of the map.
  always_comb begin
    if (32'(blk_cnt_q) > 32'(NUM_BLOCKS)) begin
      eff = CNT_W'(NUM_BLOCKS);
    end else begin
      eff = blk_cnt_q;
    end
  end

  assign eff_m1     = eff - CNT_W'(1);
  assign first_word = ADDR_W'(first_q[BLK_W-1:BIT_W]);
  assign last_word  = ADDR_W'(eff_m1[CNT_W-1:BIT_W]);
  assign in_oor     = {1'b0, in_data_i.block} >= eff;
  assign alloc_none = {1'b0, first_q} >= eff;

  assign in_stall_o = (state_q != S_IDLE);
  assign in_xfer    = in_valid_i && !in_stall_o;
  assign req_onehot = WORD_W'(1) << req_q.block[BIT_W-1:0];

  assign scan_ctl.is_first = (chk_addr_q == first_word);
  assign scan_ctl.is_last  = (chk_addr_q == last_word);
  assign scan_ctl.lo_bit   = first_q[BIT_W-1:0];
  assign scan_ctl.hi_bit   = eff_m1[BIT_W-1:0];

  bba_word_scan u_scan (
    .word_i (ram_rdata),
    .ctl_i  (scan_ctl),
    .res_o  (scan_res)
  );

  bba_ram #(
    .WIDTH (WORD_W),
    .DEPTH (DEPTH)
  ) u_map (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    state_d     = state_q;
    clr_d       = clr_q;
    scan_addr_d = scan_addr_q;
    chk_addr_d  = chk_addr_q;
    chk_vld_d   = 1'b0;
    iss_done_d  = iss_done_q;
    req_d       = req_q;
    res_d       = res_q;
    out_d       = out_q;
    out_vld_d   = out_vld_q && out_stall_i;
    ram_we      = 1'b0;
    ram_waddr   = clr_q;
    ram_wdata   = '0;
    ram_re      = 1'b0;
    ram_raddr   = ADDR_W'(req_q.block[BLK_W-1:BIT_W]);

    case (state_q)
      S_CLEAR: begin
        ram_we = 1'b1;
        clr_d  = clr_q + ADDR_W'(1);
        if (clr_q == ADDR_W'(DEPTH - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_xfer) begin
          req_d = in_data_i;
          res_d = '0;
          if (in_data_i.func == FUNC_ALLOC) begin
            scan_addr_d = first_word;
            iss_done_d  = 1'b0;
            state_d     = alloc_none ? S_DONE : S_SCAN;
          end else begin
            res_d.out_of_range = in_oor;
            res_d.block_used   = in_oor && (in_data_i.func == FUNC_QUERY);
            state_d            = in_oor ? S_DONE : S_RD;
          end
        end
      end
      S_RD: begin
        ram_re  = 1'b1;
        state_d = S_MOD;
      end
      S_MOD: begin
        ram_waddr = ADDR_W'(req_q.block[BLK_W-1:BIT_W]);
        case (req_q.func)
          FUNC_FREE: begin
            ram_we    = 1'b1;
            ram_wdata = ram_rdata & ~req_onehot;
          end
          FUNC_MARK: begin
            ram_we    = 1'b1;
            ram_wdata = ram_rdata | req_onehot;
          end
          FUNC_QUERY: res_d.block_used = ram_rdata[req_q.block[BIT_W-1:0]];
          default: ;
        endcase
        state_d = S_DONE;
      end
      S_SCAN: begin
        // Reads run one word ahead of the check.
        ram_re    = !iss_done_q;
        ram_raddr = scan_addr_q;
        if (!iss_done_q) begin
          if (scan_addr_q == last_word) begin
            iss_done_d = 1'b1;
          end else begin
            scan_addr_d = scan_addr_q + ADDR_W'(1);
          end
        end
        chk_vld_d  = !iss_done_q;
        chk_addr_d = scan_addr_q;
        if (chk_vld_q) begin
          if (scan_res.found) begin
            ram_we              = 1'b1;
            ram_waddr           = chk_addr_q;
            ram_wdata           = ram_rdata | (WORD_W'(1) << scan_res.bit_idx);
            res_d.granted_block = BLK_W'({chk_addr_q, scan_res.bit_idx});
            res_d.alloc_ok      = 1'b1;
            chk_vld_d           = 1'b0;
            state_d             = S_DONE;
          end else if (chk_addr_q == last_word) begin
            chk_vld_d = 1'b0;
            state_d   = S_DONE;
          end
        end
      end
      S_DONE: begin
        if (!out_vld_q || !out_stall_i) begin
          out_d     = res_q;
          out_vld_d = 1'b1;
          state_d   = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_CLEAR;
      clr_q      <= '0;
      chk_vld_q  <= 1'b0;
      iss_done_q <= 1'b0;
      out_vld_q  <= 1'b0;
    end else begin
      state_q    <= state_d;
      clr_q      <= clr_d;
      chk_vld_q  <= chk_vld_d;
      iss_done_q <= iss_done_d;
      out_vld_q  <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    scan_addr_q <= scan_addr_d;
    chk_addr_q  <= chk_addr_d;
    req_q       <= req_d;
    res_q       <= res_d;
    out_q       <= out_d;
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

endmodule
`default_nettype wire

// File: tb/tb_bitmap_block_allocator.sv
// Self-checking testbench for the bitmap first-fit block allocator.
`timescale 1ns / 100ps
module tb_bitmap_block_allocator;
  import bba_pkg::*;

  localparam int unsigned NUM_BLOCKS = 1024;
  localparam int unsigned RAND_ITEMS = 1050;

  typedef enum logic {ROW_REQ, ROW_CFG} row_kind_e;

  // One line of the directed plan: a request or a register write.
  typedef struct packed {
    row_kind_e        kind;
    logic [1:0]       code;
    logic [CFG_W-1:0] value;
    logic             has_exp;
    bba_out_t         exp;
  } row_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 in_valid_i = 1'b0;
  logic                 in_stall_o;
  bba_in_t              in_data_i = '0;
  logic                 out_valid_o;
  logic                 out_stall_i = 1'b0;
  bba_out_t             out_data_o;
  logic                 cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i = '0;
  logic [CFG_W-1:0]     cfg_wdata_i = '0;

  bitmap_block_allocator #(.NUM_BLOCKS(NUM_BLOCKS)) dut (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Shadow of the allocator state
  logic             block_taken [NUM_BLOCKS];
  logic [CNT_W-1:0] disk_blocks = '0;
  logic [BLK_W-1:0] alloc_start = '0;

  bba_out_t    pending_results[$];
  row_t        plan_q[$];
  int unsigned n_fail = 0;
  int unsigned n_checked = 0;
  int unsigned n_granted = 0;
  int unsigned n_missed = 0;
  int unsigned n_oor = 0;
  int unsigned n_settings = 0;

  function automatic int unsigned usable_blocks();
    return (32'(disk_blocks) > NUM_BLOCKS) ? NUM_BLOCKS : 32'(disk_blocks);
  endfunction

  function automatic bba_out_t allocator_response(bba_in_t req);
    bba_out_t    r;
    int unsigned lim;
    logic        oor;
    r   = '0;
    lim = usable_blocks();
    oor = (32'(req.block) >= lim);
    case (req.func)
      FUNC_ALLOC: begin
        for (int unsigned i = 32'(alloc_start); i < lim && !r.alloc_ok; i++) begin
          if (!block_taken[i]) begin
            block_taken[i]  = 1'b1;
            r.granted_block = i[BLK_W-1:0];
            r.alloc_ok      = 1'b1;
          end
        end
        if (!r.alloc_ok) n_missed++;
      end
      FUNC_FREE: begin
        r.out_of_range = oor;
        if (!oor) block_taken[req.block] = 1'b0;
      end
      FUNC_MARK: begin
        r.out_of_range = oor;
        if (!oor) block_taken[req.block] = 1'b1;
      end
      default: begin
        r.out_of_range = oor;
        r.block_used   = oor ? 1'b1 : block_taken[req.block];
      end
    endcase
    return r;
  endfunction

  function automatic bba_out_t mk_res(int unsigned g, int unsigned ok, int unsigned used,
                                      int unsigned oor);
    bba_out_t r;
    r.granted_block = g[BLK_W-1:0];
    r.alloc_ok      = ok[0];
    r.block_used    = used[0];
    r.out_of_range  = oor[0];
    return r;
  endfunction

  function automatic void plan_row(row_kind_e kind, logic [1:0] code, int unsigned val,
                                   bit has_exp, bba_out_t exp);
    row_t row;
    row.kind    = kind;
    row.code    = code;
    row.value   = val[CFG_W-1:0];
    row.has_exp = has_exp;
    row.exp     = exp;
    plan_q.push_back(row);
  endfunction

  function automatic void plan_req(func_e f, int unsigned blk);
    plan_row(ROW_REQ, f, blk, 1'b0, '0);
  endfunction

  function automatic void plan_chk(func_e f, int unsigned blk, bba_out_t exp);
    plan_row(ROW_REQ, f, blk, 1'b1, exp);
  endfunction

  function automatic void plan_cfg(cfg_idx_e idx, int unsigned val);
    plan_row(ROW_CFG, {1'b0, idx}, val, 1'b0, '0);
  endfunction

  // Random block: mostly inside the disk, now and then anywhere.
  function automatic logic [BLK_W-1:0] pick_block();
    int unsigned lim;
    lim = usable_blocks();
    if (lim == 0 || $urandom_range(0, 7) == 0) return BLK_W'($urandom_range(0, NUM_BLOCKS - 1));
    return BLK_W'($urandom_range(0, lim - 1));
  endfunction

  task automatic send_req(input bba_in_t req, input bit has_exp, input bba_out_t exp);
    bba_out_t predicted;
    in_valid_i <= 1'b1;
    in_data_i  <= req;
    do @(posedge clk_i); while (in_stall_o);
    predicted = allocator_response(req);
    pending_results.push_back(has_exp ? exp : predicted);
  endtask

  task automatic idle_gap(input int unsigned n);
    in_valid_i <= 1'b0;
    repeat (n) @(posedge clk_i);
  endtask

  // Hold off the sender until every outstanding transfer has come back.
  task automatic settle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (3) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [CFG_W-1:0] val);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == CFG_BLOCK_COUNT) disk_blocks = val;
    else alloc_start = val[BLK_W-1:0];
    n_settings++;
    @(posedge clk_i);
  endtask

  task automatic check_field(input string name, input int unsigned exp, input int unsigned got);
    if (exp != got) begin
      $error("%s: expected %0d, got %0d", name, exp, got);
      n_fail++;
    end
  endtask

  // Result checker
  always @(posedge clk_i) begin : check_results
    bba_out_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_results.size() == 0) begin
        $error("result with nothing outstanding: %h", out_data_o);
        n_fail++;
      end else begin
        want = pending_results.pop_front();
        check_field("granted_block", 32'(want.granted_block),
                    32'(out_data_o.granted_block));
        check_field("alloc_ok", 32'(want.alloc_ok), 32'(out_data_o.alloc_ok));
        check_field("block_used", 32'(want.block_used), 32'(out_data_o.block_used));
        check_field("out_of_range", 32'(want.out_of_range), 32'(out_data_o.out_of_range));
        n_checked++;
        if (out_data_o.alloc_ok) n_granted++;
        if (out_data_o.out_of_range) n_oor++;
      end
    end
  end

  // Receiver back-pressure: modes change over windows of random length
  int unsigned stall_mode = 0;
  int unsigned stall_run = 0;
  always @(posedge clk_i) begin
    if (stall_run == 0) begin
      stall_mode <= $urandom_range(0, 3);
      stall_run  <= $urandom_range(20, 200);
    end else begin
      stall_run <= stall_run - 1;
    end
    case (stall_mode)
      0: out_stall_i <= 1'b0;
      1: out_stall_i <= ($urandom_range(0, 3) == 0);
      2: out_stall_i <= 1'($urandom_range(0, 1));
      default: out_stall_i <= ($urandom_range(0, 7) != 0);
    endcase
  end

  initial begin
    #10_000_000;
    $display("timeout with %0d transfers outstanding", pending_results.size());
    $display("FAIL");
    $finish;
  end

  initial begin
    bba_in_t     req;
    int unsigned n_items;
    int unsigned phase_len;
    int unsigned burst_left;
    int unsigned cnt;
    int unsigned start;
    int unsigned w;
    bit          gappy;

    foreach (block_taken[i]) block_taken[i] = 1'b0;

    // After reset: empty disk, allocate misses and every block is out of range
    plan_chk(FUNC_ALLOC, 0, mk_res(0, 0, 0, 0));
    plan_chk(FUNC_QUERY, 0, mk_res(0, 0, 1, 1));
    plan_chk(FUNC_FREE, 1023, mk_res(0, 0, 0, 1));
    plan_chk(FUNC_MARK, 0, mk_res(0, 0, 0, 1));
    // Count above capacity saturates
    plan_cfg(CFG_BLOCK_COUNT, 2047);
    plan_cfg(CFG_FIRST_DATA, 0);
    plan_chk(FUNC_ALLOC, 0, mk_res(0, 1, 0, 0));
    plan_req(FUNC_ALLOC, 0);
    plan_chk(FUNC_QUERY, 1023, mk_res(0, 0, 0, 0));
    plan_req(FUNC_MARK, 1023);
    plan_chk(FUNC_QUERY, 1023, mk_res(0, 0, 1, 0));
    plan_req(FUNC_FREE, 0);
    plan_req(FUNC_QUERY, 0);
    plan_req(FUNC_ALLOC, 1023);
    // Highest start: taken block gives a miss, then the last block is granted
    plan_cfg(CFG_FIRST_DATA, 1023);
    plan_chk(FUNC_ALLOC, 0, mk_res(0, 0, 0, 0));
    plan_req(FUNC_FREE, 1023);
    plan_chk(FUNC_ALLOC, 0, mk_res(1023, 1, 0, 0));
    // One-block disk, start past the count
    plan_cfg(CFG_BLOCK_COUNT, 1);
    plan_chk(FUNC_QUERY, 1, mk_res(0, 0, 1, 1));
    plan_chk(FUNC_ALLOC, 0, mk_res(0, 0, 0, 0));
    plan_cfg(CFG_FIRST_DATA, 0);
    plan_chk(FUNC_ALLOC, 0, mk_res(0, 0, 0, 0));
    plan_req(FUNC_FREE, 0);
    plan_chk(FUNC_ALLOC, 0, mk_res(0, 1, 0, 0));
    plan_cfg(CFG_BLOCK_COUNT, 1024);
    plan_req(FUNC_QUERY, 1023);
    plan_req(FUNC_QUERY, 512);
    plan_req(FUNC_MARK, 682);
    plan_req(FUNC_QUERY, 341);

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    // wait out the bitmap clearing pass
    while (in_stall_o) @(posedge clk_i);

    foreach (plan_q[k]) begin
      if (plan_q[k].kind == ROW_CFG) begin
        settle();
        write_reg(cfg_idx_e'(plan_q[k].code[CFG_IDX_W-1:0]), plan_q[k].value);
      end else begin
        req.func  = func_e'(plan_q[k].code);
        req.block = plan_q[k].value[BLK_W-1:0];
        send_req(req, plan_q[k].has_exp, plan_q[k].exp);
      end
    end

    n_items    = 0;
    burst_left = 0;
    while (n_items < RAND_ITEMS) begin
      settle();
      case ($urandom_range(0, 6))
        0, 1:    cnt = $urandom_range(1, 40);
        2:       cnt = $urandom_range(1, 200);
        3:       cnt = NUM_BLOCKS;
        4:       cnt = $urandom_range(NUM_BLOCKS + 1, 2047);
        5:       cnt = $urandom_range(0, 3);
        default: cnt = $urandom_range(0, 2047);
      endcase
      case ($urandom_range(0, 4))
        0:       start = 0;
        1:       start = $urandom_range(0, (cnt > 1023) ? 1023 : cnt);
        2:       start = (cnt > 1023) ? 1023 : cnt;
        3:       start = $urandom_range(0, 2047);  // top bit is dropped
        default: start = $urandom_range(0, 7);
      endcase
      write_reg(CFG_BLOCK_COUNT, cnt[CFG_W-1:0]);
      write_reg(CFG_FIRST_DATA, start[CFG_W-1:0]);

      gappy     = ($urandom_range(0, 3) != 0);
      phase_len = $urandom_range(40, 120);
      if (phase_len > RAND_ITEMS - n_items) phase_len = RAND_ITEMS - n_items;
      repeat (phase_len) begin
        w = $urandom_range(0, 99);
        if (w < 40) req.func = FUNC_ALLOC;
        else if (w < 60) req.func = FUNC_FREE;
        else if (w < 75) req.func = FUNC_MARK;
        else req.func = FUNC_QUERY;
        req.block = pick_block();
        send_req(req, 1'b0, '0);
        n_items++;
        if ($urandom_range(0, 60) == 0) begin
          settle();
        end else if (burst_left == 0) begin
          burst_left = $urandom_range(1, 24);
          if (gappy) idle_gap($urandom_range(1, 10));
        end else begin
          burst_left--;
        end
      end
    end

    settle();
    repeat (40) @(posedge clk_i);
    $display("%0d transfers checked over %0d register writes", n_checked, n_settings);
    $display("%0d blocks granted, %0d allocate misses, %0d out-of-range requests",
             n_granted, n_missed, n_oor);
    if (n_fail == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
